// File: rtl/core/id3fw_pkg.sv
// ----------------------------------------------------------------------------
// id3fw_pkg
// Shared types and constants for the ID3v2 frame walker.
// ----------------------------------------------------------------------------
package id3fw_pkg;

    // Width of byte offsets and of the region length.
    localparam int OFFSET_BITS = 28;
    // Frame size including the header: a 32-bit size plus a header length.
    localparam int SIZE_W      = 33;
    // Wide enough for a frame start plus a full frame size.
    localparam int LIMIT_W     = 34;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [3:0] HLEN_SHORT = 4'd6;   // v2.2 header bytes
    localparam logic [3:0] HLEN_LONG  = 4'd10;  // v2.3 and v2.4 header bytes
    localparam logic [3:0] IDLEN_SHORT = 4'd3;
    localparam logic [3:0] IDLEN_LONG  = 4'd4;
    localparam logic [3:0] HIDX_MAX    = 4'd15;

    localparam logic [15:0] SKIP_FLAGS_V23 = 16'h00c0;
    localparam logic [15:0] SKIP_FLAGS_V24 = 16'h000c;
    localparam logic [31:0] SYNCSAFE_HIGH  = 32'h80808080;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_VERSION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ANY     = 2'd3;

    // Tag version codes; code 3 behaves as v2.4.
    localparam logic [1:0] VER_22 = 2'd0;
    localparam logic [1:0] VER_23 = 2'd1;
    localparam logic [1:0] VER_24 = 2'd2;

    typedef enum logic [2:0] {
        ST_MATCH     = 3'd0,
        ST_PADDING   = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_PARTIAL   = 3'd3,
        ST_SYNCSAFE  = 3'd4,
        ST_NO_ROOM   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]             tag_version;
        logic [OFFSET_BITS-1:0] region_length;
        logic [31:0]            target_id;
        logic                   match_any;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [OFFSET_BITS-1:0] position;
        logic [OFFSET_BITS-1:0] frame_start;
        logic [3:0]             header_index;
        logic [31:0]            id_shift;      // frame ID bytes
        logic [47:0]            sf_shift;      // size and flag bytes
        logic [31:0]            payload_remaining;
    } walk_state_t;

    typedef struct packed {
        status_t                status;
        logic [OFFSET_BITS-1:0] frame_offset;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [SIZE_W-1:0]      frame_size;
        logic [31:0]            frame_id;
        logic [15:0]            frame_flags;
    } result_t;

endpackage

// File: rtl/core/id3fw_cfg.sv
// ----------------------------------------------------------------------------
// id3fw_cfg
// Configuration register file of the frame walker, written by index.
// ----------------------------------------------------------------------------
module id3fw_cfg
    import id3fw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TAG_VERSION:   cfg_next.tag_version   = cfg_wdata[1:0];
                CFG_REGION_LENGTH: cfg_next.region_length = cfg_wdata[OFFSET_BITS-1:0];
                CFG_TARGET_ID:     cfg_next.target_id     = cfg_wdata[31:0];
                CFG_MATCH_ANY:     cfg_next.match_any     = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tag_version   <= VER_24;
            cfg_reg.region_length <= '0;
            cfg_reg.target_id     <= '0;
            cfg_reg.match_any     <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/id3fw_step.sv
// ----------------------------------------------------------------------------
// id3fw_step
// Next-state and result logic for one tag byte of the frame walk.
// ----------------------------------------------------------------------------
module id3fw_step
    import id3fw_pkg::*;
(
    input  cfg_t        cfg,
    input  walk_state_t cur,
    input  logic [7:0]  data_byte,
    output walk_state_t nxt,
    output logic        res_valid,
    output result_t     res
);

    logic                   v22;
    logic                   v23;
    logic [3:0]             hlen;
    logic [3:0]             idlen;
    logic [OFFSET_BITS:0]   room_sum;
    logic                   no_room;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] start;
    logic [31:0]            id_base;
    logic [47:0]            sf_base;
    logic [31:0]            id_new;
    logic [47:0]            sf_new;
    logic                   hdr_more;
    logic [31:0]            id_val;
    logic [15:0]            flags;
    logic [31:0]            raw;
    logic [31:0]            base;
    logic                   bad_sync;
    logic [SIZE_W-1:0]      total;
    logic [LIMIT_W-1:0]     fit_sum;
    logic                   partial;
    logic [OFFSET_BITS-1:0] po;
    logic                   skip;
    logic                   hit;
    logic [31:0]            rem_dec;

    always_comb begin
        v22      = (cfg.tag_version == VER_22);
        v23      = (cfg.tag_version == VER_23);
        hlen     = v22 ? HLEN_SHORT : HLEN_LONG;
        idlen    = v22 ? IDLEN_SHORT : IDLEN_LONG;
        pos_inc  = cur.position + OFFSET_BITS'(1);
        room_sum = (OFFSET_BITS+1)'(cur.position) + (OFFSET_BITS+1)'(hlen);
        no_room  = (cur.header_index == '0)
                && (room_sum > (OFFSET_BITS+1)'(cfg.region_length));

        // A new header starts from cleared shift registers.
        start   = (cur.header_index == '0) ? cur.position : cur.frame_start;
        id_base = (cur.header_index == '0) ? '0 : cur.id_shift;
        sf_base = (cur.header_index == '0) ? '0 : cur.sf_shift;
        id_new  = id_base;
        sf_new  = sf_base;
        if (cur.header_index < idlen) begin
            id_new = {id_base[23:0], data_byte};
        end else begin
            sf_new = {sf_base[39:0], data_byte};
        end
        hdr_more = (5'(cur.header_index) + 5'd1) < 5'(hlen);

        // Decode of the completed header.
        id_val   = v22 ? {8'h00, id_new[23:0]} : id_new;
        flags    = v22 ? 16'h0000 : sf_new[15:0];
        raw      = v22 ? {8'h00, sf_new[23:0]} : sf_new[47:16];
        bad_sync = !v22 && !v23 && ((raw & SYNCSAFE_HIGH) != '0);
        base     = (v22 || v23) ? raw
                 : {4'h0, raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
        total    = SIZE_W'(base) + SIZE_W'(hlen);
        fit_sum  = LIMIT_W'(start) + LIMIT_W'(total);
        partial  = fit_sum > LIMIT_W'(cfg.region_length);
        po       = start + OFFSET_BITS'(hlen);
        skip     = v22 ? 1'b0
                 : v23 ? ((flags & SKIP_FLAGS_V23) != '0)
                 : ((flags & SKIP_FLAGS_V24) != '0);
        hit      = cfg.match_any
                || (id_val == (v22 ? {8'h00, cfg.target_id[23:0]} : cfg.target_id));

        rem_dec  = (cur.payload_remaining != '0) ? cur.payload_remaining - 32'd1
                                                 : cur.payload_remaining;

        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        res.status = ST_MATCH;

        unique case (cur.phase)
            PH_PAYLOAD: begin
                nxt.position          = pos_inc;
                nxt.payload_remaining = rem_dec;
                if (rem_dec == '0) begin
                    nxt.phase        = PH_HEADER;
                    nxt.header_index = '0;
                end
            end
            PH_HEADER: begin
                if (no_room) begin
                    nxt.phase          = PH_DONE;
                    res_valid          = 1'b1;
                    res.status         = ST_NO_ROOM;
                    res.frame_offset   = cur.position;
                    res.payload_offset = room_sum[OFFSET_BITS-1:0];
                end else begin
                    nxt.frame_start = start;
                    nxt.id_shift    = id_new;
                    nxt.sf_shift    = sf_new;
                    nxt.position    = pos_inc;
                    if (hdr_more) begin
                        if (cur.header_index < HIDX_MAX) begin
                            nxt.header_index = cur.header_index + 4'd1;
                        end
                    end else begin
                        nxt.header_index   = '0;
                        res.frame_offset   = start;
                        res.payload_offset = po;
                        res.frame_id       = id_val;
                        res.frame_flags    = flags;
                        priority if (id_val == '0) begin
                            nxt.phase  = PH_DONE;
                            res_valid  = 1'b1;
                            res.status = ST_PADDING;
                        end else if (bad_sync) begin
                            nxt.phase  = PH_DONE;
                            res_valid  = 1'b1;
                            res.status = ST_SYNCSAFE;
                        end else if (base == '0) begin
                            nxt.phase  = PH_DONE;
                            res_valid  = 1'b1;
                            res.status = ST_ZERO_SIZE;
                        end else if (partial) begin
                            nxt.phase      = PH_DONE;
                            res_valid      = 1'b1;
                            res.status     = ST_PARTIAL;
                            res.frame_size = total;
                        end else begin
                            nxt.phase             = PH_PAYLOAD;
                            nxt.payload_remaining = base;
                            res_valid             = !skip && hit;
                            res.status            = ST_MATCH;
                            res.frame_size        = total;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/id3v2_frame_walker_top.sv
// ----------------------------------------------------------------------------
// id3v2_frame_walker_top
// Walks the frames of an ID3v2 tag body one byte per transfer and reports
// matching frames and the status that ends the walk.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_data_byte (one tag body byte)
//   m_        out        m_valid / m_ready   m_status, offsets, size, ID, flags
//   cfg_      in         cfg_wr_en           cfg_index, cfg_wdata (no read-back)
//
// One byte is taken per clock cycle when the result side keeps up. A byte
// is held in the input register and its result, if any, is loaded into the
// output register when the byte is processed, from which the result can
// itself be transferred. The input register refills while a finished result
// waits, so a stall on the result side only holds the block once both
// registers are full. Reset (aresetn low at a rising edge of aclk) restores
// the register defaults and the start of a walk.
// ----------------------------------------------------------------------------
module id3v2_frame_walker_top
    import id3fw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [OFFSET_BITS-1:0] m_frame_offset,
    output logic [OFFSET_BITS-1:0] m_payload_offset,
    output logic [SIZE_W-1:0]      m_frame_size,
    output logic [31:0]            m_frame_id,
    output logic [15:0]            m_frame_flags
);

    cfg_t        cfg;
    walk_state_t state_reg;
    walk_state_t state_next;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        res_valid;
    result_t     res;
    logic        advance;

    // Configuration registers take effect at once on the walk logic.
    id3fw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The step logic sees the held byte and the walk state and gives the
    // next state together with at most one result.
    id3fw_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // The held byte is processed whenever the output register is free or is
    // being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Walk state: position, header gathering and payload countdown.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_HEADER, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register: loaded when a processed byte yields a result,
    // emptied when the downstream side completes a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_reg.status;
    assign m_frame_offset   = out_reg.frame_offset;
    assign m_payload_offset = out_reg.payload_offset;
    assign m_frame_size     = out_reg.frame_size;
    assign m_frame_id       = out_reg.frame_id;
    assign m_frame_flags    = out_reg.frame_flags;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives an ID3v2 tag body into id3v2_frame_walker_top one byte per transfer,
// predicts every match and the status that ends the walk, and compares the
// results field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import id3fw_pkg::*;

    // The run is bounded by this many clock cycles; a correct run needs only
    // a small fraction of it, even with heavy idling on both sides.
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_status;
    logic [OFFSET_BITS-1:0] m_frame_offset;
    logic [OFFSET_BITS-1:0] m_payload_offset;
    logic [SIZE_W-1:0]      m_frame_size;
    logic [31:0]            m_frame_id;
    logic [15:0]            m_frame_flags;

    id3v2_frame_walker_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_offset   (m_frame_offset),
        .m_payload_offset (m_payload_offset),
        .m_frame_size     (m_frame_size),
        .m_frame_id       (m_frame_id),
        .m_frame_flags    (m_frame_flags)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bookkeeping. The stimulus process fills tag_bytes; the byte
    // driver empties it. expected_frames holds the predicted results in the
    // order the block must deliver them.
    // ------------------------------------------------------------------------
    logic [7:0]   tag_bytes[$];
    result_t      expected_frames[$];
    int unsigned  src_idle_pct = 0;
    int unsigned  sink_stall_pct = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;

    // The block's registers as last written, starting from their reset values.
    logic [1:0]             cfg_version = VER_24;
    logic [OFFSET_BITS-1:0] cfg_region = '0;
    logic [31:0]            cfg_target = '0;
    logic                   cfg_all = 1'b1;

    // Walk state of the prediction; it mirrors what the block must hold.
    phase_t                 walk_ph = PH_HEADER;
    logic [OFFSET_BITS-1:0] pos = '0;
    logic [OFFSET_BITS-1:0] frm_start = '0;
    logic [3:0]             hdr_idx = '0;
    logic [31:0]            id_bytes = '0;
    logic [47:0]            sf_bytes = '0;
    logic [SIZE_W-1:0]      pay_left = '0;

    function automatic void note_result(input status_t st,
                                        input logic [OFFSET_BITS-1:0] fo,
                                        input logic [OFFSET_BITS-1:0] po,
                                        input logic [SIZE_W-1:0] fsize,
                                        input logic [31:0] fid,
                                        input logic [15:0] fflags);
        result_t r;
        r.status         = st;
        r.frame_offset   = fo;
        r.payload_offset = po;
        r.frame_size     = fsize;
        r.frame_id       = fid;
        r.frame_flags    = fflags;
        expected_frames.push_back(r);
    endfunction

    // Advances the predicted walk by one accepted tag byte. A finished
    // header is checked in the same order as the block does: padding, then
    // the syncsafe form, then a zero size, then whether the frame fits.
    task automatic walk_byte(input logic [7:0] b);
        logic                   short_hdr;
        logic [3:0]             hlen;
        logic [3:0]             idlen;
        logic [31:0]            fid;
        logic [31:0]            raw;
        logic [15:0]            fflags;
        logic [SIZE_W-1:0]      base;
        logic [SIZE_W-1:0]      total;
        logic [OFFSET_BITS-1:0] po;
        logic                   skip;
        short_hdr = (cfg_version == VER_22);
        hlen      = short_hdr ? HLEN_SHORT : HLEN_LONG;
        idlen     = short_hdr ? IDLEN_SHORT : IDLEN_LONG;
        if (walk_ph == PH_DONE) return;
        if (walk_ph == PH_PAYLOAD) begin
            pos = pos + 1'b1;
            if (pay_left != 0) pay_left = pay_left - 1'b1;
            if (pay_left == 0) begin
                walk_ph = PH_HEADER;
                hdr_idx = '0;
            end
            return;
        end
        if (hdr_idx == 0) begin
            // No room for another header: the walk stops at this byte.
            if (34'(pos) + 34'(hlen) > 34'(cfg_region)) begin
                walk_ph = PH_DONE;
                note_result(ST_NO_ROOM, pos, pos + OFFSET_BITS'(hlen), '0, '0, '0);
                return;
            end
            frm_start = pos;
            id_bytes  = '0;
            sf_bytes  = '0;
        end
        if (hdr_idx < idlen) id_bytes = {id_bytes[23:0], b};
        else sf_bytes = {sf_bytes[39:0], b};
        pos = pos + 1'b1;
        if (5'(hdr_idx) + 5'd1 < 5'(hlen)) begin
            if (hdr_idx < HIDX_MAX) hdr_idx++;
            return;
        end

        hdr_idx = '0;
        fid     = short_hdr ? {8'd0, id_bytes[23:0]} : id_bytes;
        fflags  = short_hdr ? 16'd0 : sf_bytes[15:0];
        raw     = short_hdr ? {8'd0, sf_bytes[23:0]} : sf_bytes[47:16];
        po      = frm_start + OFFSET_BITS'(hlen);
        if (fid == 0) begin
            walk_ph = PH_DONE;
            note_result(ST_PADDING, frm_start, po, '0, fid, fflags);
            return;
        end
        if (!short_hdr && cfg_version != VER_23) begin
            if ((raw & SYNCSAFE_HIGH) != 0) begin
                walk_ph = PH_DONE;
                note_result(ST_SYNCSAFE, frm_start, po, '0, fid, fflags);
                return;
            end
            base = SIZE_W'({raw[30:24], raw[22:16], raw[14:8], raw[6:0]});
        end else begin
            base = SIZE_W'(raw);
        end
        if (base == 0) begin
            walk_ph = PH_DONE;
            note_result(ST_ZERO_SIZE, frm_start, po, '0, fid, fflags);
            return;
        end
        total = base + SIZE_W'(hlen);
        if (34'(frm_start) + 34'(total) > 34'(cfg_region)) begin
            walk_ph = PH_DONE;
            note_result(ST_PARTIAL, frm_start, po, total, fid, fflags);
            return;
        end
        pay_left = base;
        walk_ph  = PH_PAYLOAD;
        // Compressed or encrypted frames are stepped over
        // quietly; v2.2 has no flag word at all.
        if (short_hdr) skip = 1'b0;
        else if (cfg_version == VER_23) skip = (fflags & SKIP_FLAGS_V23) != 0;
        else skip = (fflags & SKIP_FLAGS_V24) != 0;
        if (skip) return;
        if (cfg_all || fid == (short_hdr ? {8'd0, cfg_target[23:0]} : cfg_target)) begin
            note_result(ST_MATCH, frm_start, po, total, fid, fflags);
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte driver. A new byte is offered only once the previous transfer has
    // happened, so valid and the byte stay put while the block holds off.
    // The prediction is advanced at the very edge that completes a transfer.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) walk_byte(s_data_byte);
            if (tag_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_valid     <= 1'b1;
                s_data_byte <= tag_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result transfer is compared with the oldest
    // prediction; ready is drawn afresh every cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result at cycle %0d: status %0d frame %0h id %h",
                                 cycle_count, m_status, m_frame_offset, m_frame_id);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (m_status != want.status || m_frame_offset != want.frame_offset ||
                        m_payload_offset != want.payload_offset ||
                        m_frame_size != want.frame_size || m_frame_id != want.frame_id ||
                        m_frame_flags != want.frame_flags) begin
                        if (mismatch_count < 10) begin
                            $display("result mismatch at cycle %0d", cycle_count);
                            $display("  expected status %0d frame %0h payload %0h size %0h id %h flags %h",
                                     want.status, want.frame_offset, want.payload_offset,
                                     want.frame_size, want.frame_id, want.frame_flags);
                            $display("  actual   status %0d frame %0h payload %0h size %0h id %h flags %h",
                                     m_status, m_frame_offset, m_payload_offset,
                                     m_frame_size, m_frame_id, m_frame_flags);
                        end
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("id3v2_frame_walker_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] stim_pos = '0;   // offset of the next byte queued

    function automatic logic [31:0] to_syncsafe(input logic [27:0] n);
        return {1'b0, n[27:21], 1'b0, n[20:14], 1'b0, n[13:7], 1'b0, n[6:0]};
    endfunction

    function automatic void set_idling(input int unsigned mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
            default: begin src_idle_pct = 16; sink_stall_pct = 16; end
        endcase
    endfunction

    // Waits until every byte has been taken and every result delivered, then
    // lets the pipeline drain of bytes that cause no result.
    task automatic wait_idle();
        do @(negedge aclk);
        while (tag_bytes.size() != 0 || s_valid || expected_frames.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TAG_VERSION:   cfg_version = val[1:0];
            CFG_REGION_LENGTH: cfg_region  = val[OFFSET_BITS-1:0];
            CFG_TARGET_ID:     cfg_target  = val;
            CFG_MATCH_ANY:     cfg_all     = val[0];
        endcase
    endtask

    // Writes all four registers back to back. Unused upper bits of the write
    // data are sometimes filled with noise, which the block must ignore.
    task automatic setup_phase(input logic [1:0] ver, input logic [OFFSET_BITS-1:0] region,
                               input logic [31:0] target, input logic match_all);
        logic noisy;
        noisy = 1'($urandom_range(0, 1));
        write_reg(CFG_TAG_VERSION, {noisy ? 30'($urandom) : 30'd0, ver});
        write_reg(CFG_REGION_LENGTH, {noisy ? 4'($urandom) : 4'd0, region});
        write_reg(CFG_TARGET_ID, target);
        write_reg(CFG_MATCH_ANY, {noisy ? 31'($urandom) : 31'd0, match_all});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queues one frame: header in the layout of the given version, then a
    // payload of random bytes. size_field is already in its coded form.
    task automatic push_frame(input logic [1:0] ver, input logic [31:0] fid,
                              input logic [15:0] fflags, input logic [31:0] size_field,
                              input int unsigned body_len);
        int unsigned n;
        if (ver == VER_22) begin
            for (n = 0; n < 3; n++) tag_bytes.push_back(fid[23 - 8 * n -: 8]);
            for (n = 0; n < 3; n++) tag_bytes.push_back(size_field[23 - 8 * n -: 8]);
            stim_pos += OFFSET_BITS'(HLEN_SHORT);
        end else begin
            for (n = 0; n < 4; n++) tag_bytes.push_back(fid[31 - 8 * n -: 8]);
            for (n = 0; n < 4; n++) tag_bytes.push_back(size_field[31 - 8 * n -: 8]);
            tag_bytes.push_back(fflags[15:8]);
            tag_bytes.push_back(fflags[7:0]);
            stim_pos += OFFSET_BITS'(HLEN_LONG);
        end
        for (n = 0; n < body_len; n++) tag_bytes.push_back(8'($urandom));
        stim_pos += OFFSET_BITS'(body_len);
    endtask

    // A well-formed frame with random content. Most payloads are short; a
    // few run to a couple of hundred bytes so the size can span two bytes.
    task automatic rand_frame(input logic [1:0] ver, input logic match_all,
                              input logic [31:0] target);
        logic [31:0] fid;
        logic [31:0] size_field;
        logic [15:0] fflags;
        logic [15:0] skip_mask;
        int unsigned base;
        fid = (!match_all && $urandom_range(0, 1)) ? target : $urandom;
        if (ver == VER_22 ? fid[23:0] == 0 : fid == 0) fid[0] = 1'b1;
        base = ($urandom_range(0, 99) < 3) ? $urandom_range(120, 260) : $urandom_range(1, 6);
        if (ver == VER_22 || ver == VER_23) size_field = base;
        else size_field = to_syncsafe(28'(base));
        skip_mask = (ver == VER_23) ? SKIP_FLAGS_V23 : SKIP_FLAGS_V24;
        case ($urandom_range(0, 3))
            0:       fflags = '0;
            1:       fflags = 16'($urandom);
            default: fflags = 16'($urandom) & ~skip_mask;
        endcase
        push_frame(ver, fid, fflags, size_field, base);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus. A walk can end only once per reset, so the run is one long
    // walk over many frames under changing settings, and a single randomly
    // chosen ending is put at the very end of it.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned            p;
        int unsigned            hlen;
        logic [1:0]             ver;
        logic                   match_all;
        logic [31:0]            target;
        logic [31:0]            fid;
        logic [31:0]            size_field;
        logic [OFFSET_BITS-1:0] region;
        logic [OFFSET_BITS-1:0] base;
        status_t                end_kind;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening in the v2.4 layout: an all-ones frame ID that
        // matches the target with every flag bit set except the skip bits,
        // the same frame marked as compressed and encrypted, and a frame whose
        // ID differs from the target. All carry the smallest payload.
        setup_phase(VER_24, {OFFSET_BITS{1'b1}}, 32'hFFFF_FFFF, 1'b0);
        set_idling(0);
        @(negedge aclk);
        push_frame(VER_24, 32'hFFFF_FFFF, 16'hFFF3, to_syncsafe(28'd1), 1);
        push_frame(VER_24, 32'hFFFF_FFFF, SKIP_FLAGS_V24, to_syncsafe(28'd1), 1);
        push_frame(VER_24, 32'h5449_5432, 16'h0000, to_syncsafe(28'd1), 1);

        // Random phases: every layout, including code 3, and each idling
        // pattern, with the region both at its maximum and at least 5000 bytes ahead.
        for (p = 0; p < 60 && stim_pos < 450; p++) begin
            wait_idle();
            ver       = 2'((p + p / 4) % 4);
            match_all = (p % 3 != 1);
            target    = $urandom;
            region    = (p % 5 == 0) ? {OFFSET_BITS{1'b1}}
                                     : stim_pos + 28'd5000 + 28'($urandom_range(0, 999));
            setup_phase(ver, region, target, match_all);
            @(negedge aclk);
            set_idling(p % 4);
            repeat (6) rand_frame(ver, match_all, target);
        end

        // The ending: padding, a zero size, a partial frame, a size with a
        // high bit set in syncsafe form, or no room left for a header.
        wait_idle();
        end_kind = status_t'($urandom_range(int'(ST_PADDING), int'(ST_NO_ROOM)));
        ver = 2'($urandom);
        if (end_kind == ST_SYNCSAFE && (ver == VER_22 || ver == VER_23)) ver = VER_24;
        hlen   = (ver == VER_22) ? 6 : 10;
        region = {OFFSET_BITS{1'b1}};
        if (end_kind == ST_PARTIAL)
            region = stim_pos + OFFSET_BITS'(hlen) + 28'($urandom_range(0, 20));
        if (end_kind == ST_NO_ROOM)
            region = $urandom_range(0, 1) ? '0 : stim_pos + OFFSET_BITS'(hlen) - 1'b1;
        setup_phase(ver, region, $urandom, 1'($urandom));
        @(negedge aclk);
        set_idling($urandom_range(0, 3));
        fid = $urandom | 32'h1;
        case (end_kind)
            ST_PADDING:   push_frame(ver, 32'd0, 16'($urandom), $urandom, 0);
            ST_ZERO_SIZE: push_frame(ver, fid, 16'($urandom), 32'd0, 0);
            ST_PARTIAL: begin
                // Either the largest size the layout can code, or one byte
                // more than the region still holds.
                if ($urandom_range(0, 1)) begin
                    size_field = (ver == VER_22) ? 32'h00FF_FFFF :
                                 (ver == VER_23) ? 32'hFFFF_FFFF : 32'h7F7F_7F7F;
                end else begin
                    base = region - stim_pos - OFFSET_BITS'(hlen) + 1'b1;
                    size_field = (ver == VER_22 || ver == VER_23) ? 32'(base)
                                                                  : to_syncsafe(base);
                end
                push_frame(ver, fid, 16'($urandom), size_field, 0);
            end
            ST_SYNCSAFE:
                push_frame(ver, fid, 16'($urandom),
                           to_syncsafe(28'($urandom)) | (32'h80 << (8 * $urandom_range(0, 3))),
                           0);
            default:      push_frame(ver, fid, 16'($urandom), $urandom, 0);
        endcase
        // Bytes after the ending must be taken and give nothing back.
        repeat (8) tag_bytes.push_back(8'($urandom));

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("id3v2_frame_walker_top test passed");
        end else begin
            $display("id3v2_frame_walker_top test failed");
        end
        $finish;
    end

endmodule
